/* rtl/fpba_pkg.sv */
// shared types and constants of the fit-policy block allocator
// no dependencies; the rtl files other than fpba_ram use it by scoped names, the testbench imports it
package fpba_pkg;

  // defaults for the top-level parameters
  localparam int unsigned NumBlocksDef = 8;
  localparam int unsigned SizeBitsDef  = 16;

  // fixed field widths of the channels and registers
  localparam int unsigned IdxW    = 3;
  localparam int unsigned ValW    = 16;
  localparam int unsigned PolicyW = 2;
  localparam int unsigned BlocksW = 4;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [BlocksW-1:0] BlocksRst = 4'd8;

  typedef enum logic [PolicyW-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_REQ  = 1'b1
  } mode_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_POLICY = 1'b0,
    REG_BLOCKS = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [PolicyW-1:0] policy;
    logic [BlocksW-1:0] blocks_in_use;
  } cfg_t;

endpackage

/* rtl/fpba_if.sv */
// valid/ready channel interfaces for the allocator's request and result streams
// depends on fpba_pkg for the field widths
interface fpba_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [fpba_pkg::IdxW-1:0]    load_index;
  logic [fpba_pkg::ValW-1:0]    size_value;

  modport source (output valid, mode, load_index, size_value, input ready);
  modport sink   (input valid, mode, load_index, size_value, output ready);
endinterface

interface fpba_out_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [fpba_pkg::IdxW-1:0]    chosen_block;
  logic [fpba_pkg::ValW-1:0]    space_left;

  modport source (output valid, granted, chosen_block, space_left, input ready);
  modport sink   (input valid, granted, chosen_block, space_left, output ready);
endinterface

/* rtl/fpba_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module fpba_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fpba_cfg.sv */
// apb-style configuration registers: fit policy and number of blocks searched
// depends on fpba_pkg
module fpba_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::PaddrW-1:0]   paddr,
  input  logic [fpba_pkg::PdataW-1:0]   pwdata,
  output logic [fpba_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output fpba_pkg::cfg_t                cfg_o
);

  fpba_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        fpba_pkg::REG_POLICY: cfg_d.policy        = pwdata[fpba_pkg::PolicyW-1:0];
        fpba_pkg::REG_BLOCKS: cfg_d.blocks_in_use = pwdata[fpba_pkg::BlocksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy        <= fpba_pkg::POL_FIRST;
      cfg_q.blocks_in_use <= fpba_pkg::BlocksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      fpba_pkg::REG_POLICY:
        prdata = fpba_pkg::PdataW'(cfg_q.policy);
      fpba_pkg::REG_BLOCKS:
        prdata = fpba_pkg::PdataW'(cfg_q.blocks_in_use);
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/fpba_core.sv */
// allocation sequencer: free-size table in ram, one shared compare unit that
// walks the table an entry per cycle, write-back of the chosen entry, result register
// depends on fpba_pkg, fpba_if and fpba_ram
module fpba_core #(
  parameter int unsigned NUM_BLOCKS = fpba_pkg::NumBlocksDef,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SizeBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpba_pkg::cfg_t    cfg_i,
  fpba_in_if.sink           in_i,
  fpba_out_if.source        out_o
);

  localparam int unsigned AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned IW = fpba_pkg::IdxW;
  localparam int unsigned VW = fpba_pkg::ValW;

  fpba_pkg::state_e state_q, state_d;

  logic [SIZE_BITS-1:0]  req_q, req_d;
  logic [SIZE_BITS-1:0]  best_q, best_d;
  logic [AW-1:0]         pick_q, pick_d;
  logic                  found_q, found_d;
  logic [CW-1:0]         lim_q, lim_d;
  logic [CW-1:0]         rd_cnt_q, rd_cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]         cmp_idx_q, cmp_idx_d;
  logic [NUM_BLOCKS-1:0] vld_q, vld_d;

  logic                  out_vld_q, out_vld_d;
  logic                  out_gnt_q, out_gnt_d;
  logic [IW-1:0]         out_blk_q, out_blk_d;
  logic [VW-1:0]         out_left_q, out_left_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SIZE_BITS-1:0]  ram_wdata;
  logic                  ram_re;
  logic [SIZE_BITS-1:0]  ram_rdata;

  logic                  in_acc;
  logic [SIZE_BITS+VW-1:0] size_ext;
  logic [SIZE_BITS-1:0]  size_m;
  logic [AW+IW-1:0]      lidx_ext;
  logic                  lidx_ok;
  logic [CW-1:0]         lim_new;
  logic [SIZE_BITS-1:0]  entry;
  logic                  fits;
  logic                  better;
  logic [SIZE_BITS-1:0]  remain;
  logic [AW+IW-1:0]      pick_ext;
  logic [SIZE_BITS+VW-1:0] left_ext;

  assign in_i.ready = (state_q == fpba_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign size_ext = (SIZE_BITS + VW)'(in_i.size_value);
  assign size_m   = size_ext[SIZE_BITS-1:0];
  assign lidx_ext = (AW + IW)'(in_i.load_index);
  assign lidx_ok  = (32'(in_i.load_index) < NUM_BLOCKS);
  assign lim_new  = (32'(cfg_i.blocks_in_use) > NUM_BLOCKS) ? CW'(NUM_BLOCKS)
                                                            : CW'(cfg_i.blocks_in_use);

  // entries never loaded read as zero
  assign entry = vld_q[cmp_idx_q] ? ram_rdata : '0;

  // shared compare unit
  assign fits = (entry >= req_q);
  always_comb begin
    if (!found_q) begin
      better = 1'b1;
    end else begin
      case (cfg_i.policy)
        fpba_pkg::POL_BEST:  better = (entry < best_q);
        fpba_pkg::POL_WORST: better = (entry > best_q);
        default:             better = 1'b0;
      endcase
    end
  end

  assign remain   = best_q - req_q;
  assign pick_ext = (AW + IW)'(pick_q);
  assign left_ext = (SIZE_BITS + VW)'(best_q);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    best_d     = best_q;
    pick_d     = pick_q;
    found_d    = found_q;
    lim_d      = lim_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    vld_d      = vld_q;
    out_vld_d  = out_vld_q;
    out_gnt_d  = out_gnt_q;
    out_blk_d  = out_blk_q;
    out_left_d = out_left_q;
    ram_we     = 1'b0;
    ram_waddr  = pick_q;
    ram_wdata  = remain;
    ram_re     = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      fpba_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.mode == fpba_pkg::MODE_LOAD) begin
            if (lidx_ok) begin
              ram_we                    = 1'b1;
              ram_waddr                 = lidx_ext[AW-1:0];
              ram_wdata                 = size_m;
              vld_d[lidx_ext[AW-1:0]]   = 1'b1;
            end
          end else begin
            req_d    = size_m;
            lim_d    = lim_new;
            rd_cnt_d = '0;
            found_d  = 1'b0;
            best_d   = '0;
            pick_d   = '0;
            state_d  = fpba_pkg::ST_SCAN;
          end
        end
      end
      fpba_pkg::ST_SCAN: begin
        // read of entry rd_cnt overlaps the compare of the previous entry
        if (rd_cnt_q < lim_q) begin
          ram_re    = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[AW-1:0];
        end
        if (cmp_vld_q && fits && better) begin
          found_d = 1'b1;
          pick_d  = cmp_idx_q;
          best_d  = entry;
        end
        if (rd_cnt_q == lim_q && !cmp_vld_q) begin
          state_d = found_q ? fpba_pkg::ST_WRITE : fpba_pkg::ST_OUT;
        end
      end
      fpba_pkg::ST_WRITE: begin
        ram_we          = 1'b1;
        vld_d[pick_q]   = 1'b1;
        best_d          = remain;
        state_d         = fpba_pkg::ST_OUT;
      end
      fpba_pkg::ST_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_gnt_d  = found_q;
          out_blk_d  = found_q ? pick_ext[IW-1:0] : '0;
          out_left_d = found_q ? left_ext[VW-1:0] : '0;
          state_d    = fpba_pkg::ST_IDLE;
        end
      end
      default: state_d = fpba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fpba_pkg::ST_IDLE;
      found_q   <= 1'b0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      found_q   <= found_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    lim_q      <= lim_d;
    cmp_idx_q  <= cmp_idx_d;
    out_gnt_q  <= out_gnt_d;
    out_blk_q  <= out_blk_d;
    out_left_q <= out_left_d;
  end

  fpba_ram #(
    .Width (SIZE_BITS),
    .Depth (NUM_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.granted      = out_gnt_q;
  assign out_o.chosen_block = out_blk_q;
  assign out_o.space_left   = out_left_q;

endmodule

/* rtl/fit_policy_block_allocator_top.sv */
// top level of the fit-policy block allocator: config registers and sequencer
// depends on fpba_pkg, fpba_if, fpba_cfg, fpba_core (and fpba_ram below it)
//
// usage
//   in_i carries items: mode 0 loads size_value into table entry load_index,
//   mode 1 requests size_value from the table. out_o carries one result per
//   request (granted, chosen_block, space_left); loads give none.
//   policy (paddr 0) picks first, best or worst fit; blocks_in_use (paddr 4)
//   sets how many entries, lowest first, a request searches.
// sequence
//   a load does not make the block busy: in_i.ready stays high.
//   a request is handled in steps: a scan of the searched entries (the table
//   read, one compare per entry, a step to settle the pick), then, if granted,
//   a write-back of the chosen entry, then the load of the result register,
//   which waits while the output register still holds an unread result.
//   in_i.ready is low meanwhile, so the block takes no new item before the
//   result of the last request is in the result register.
// reset and stall
//   reset clears every table entry to zero through per-entry valid bits and
//   sets policy to first fit and blocks_in_use to 8. A result waits in the
//   output register while out_o.ready is low; the next item is accepted
//   meanwhile, and a further result holds back until the register frees.
module fit_policy_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS = fpba_pkg::NumBlocksDef,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fpba_in_if.sink                       in_i,
  fpba_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::PaddrW-1:0]   paddr,
  input  logic [fpba_pkg::PdataW-1:0]   pwdata,
  output logic [fpba_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  fpba_pkg::cfg_t cfg;

  fpba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fpba_core #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // a request makes the block busy in the next cycle
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.mode == fpba_pkg::MODE_REQ) |=> !in_i.ready)
    else $error("request accepted but block still ready");

  // a load never makes the block busy
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.mode == fpba_pkg::MODE_LOAD) |=> in_i.ready)
    else $error("load transaction stalled the input");

  // a new result only appears at the end of a request
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result without a request in progress");

  // a refused request reports zero index and size
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.granted |-> (out_o.chosen_block == '0) && (out_o.space_left == '0))
    else $error("refused request with nonzero fields");

endmodule

/* verif/fit_policy_block_allocator_top_tb.sv */
// self-checking testbench for fit_policy_block_allocator_top: table loads and fit requests
// depends on fpba_pkg and the fpba_in_if / fpba_out_if channel interfaces
// a scoreboard class predicts every result from its own copy of the free-size table
module fit_policy_block_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpba_pkg::*;

  localparam int unsigned Blocks      = NumBlocksDef;
  localparam int          StallLimit  = 3000;
  localparam int          HoldCycles  = 600;
  localparam int          HoldAtCount = 150;
  localparam int          SettleCycles = 16;

  typedef struct packed {
    logic            granted;
    logic [IdxW-1:0] chosen_block;
    logic [ValW-1:0] space_left;
  } grant_t;

  class alloc_scoreboard;
    logic [ValW-1:0]    free_tbl [Blocks];
    logic [PolicyW-1:0] policy;
    logic [BlocksW-1:0] blocks_in_use;
    grant_t             pending [$];
    int                 errors;

    function new();
      foreach (free_tbl[i]) free_tbl[i] = '0;
      policy        = POL_FIRST;
      blocks_in_use = BlocksRst;
      errors        = 0;
    endfunction

    function void set_reg(reg_idx_e r, logic [PdataW-1:0] v);
      if (r == REG_POLICY) policy = v[PolicyW-1:0];
      else blocks_in_use = v[BlocksW-1:0];
    endfunction

    // accepted input transaction: update the table and queue a grant for requests
    function void note_item(mode_e m, logic [IdxW-1:0] idx, logic [ValW-1:0] sz);
      int     span;
      int     pick;
      bit     found;
      grant_t g;
      if (m == MODE_LOAD) begin
        if (idx < Blocks) free_tbl[idx] = sz;
        return;
      end
      span  = (blocks_in_use > Blocks) ? Blocks : blocks_in_use;
      pick  = 0;
      found = 0;
      for (int j = 0; j < span; j++) begin
        if (free_tbl[j] < sz) continue;
        if (!found) begin
          found = 1;
          pick  = j;
          // first fit and the unused code stop at the first fit
          if (policy != POL_BEST && policy != POL_WORST) break;
        end else if (policy == POL_BEST) begin
          if (free_tbl[j] < free_tbl[pick]) pick = j;
        end else if (policy == POL_WORST) begin
          if (free_tbl[j] > free_tbl[pick]) pick = j;
        end
      end
      g = '0;
      if (found) begin
        free_tbl[pick] = free_tbl[pick] - sz;
        g.granted      = 1'b1;
        g.chosen_block = pick[IdxW-1:0];
        g.space_left   = free_tbl[pick];
      end
      pending.push_back(g);
    endfunction

    function void check_result(grant_t got);
      grant_t exp_g;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: granted %0d block %0d left %0d",
               got.granted, got.chosen_block, got.space_left);
        errors++;
        return;
      end
      exp_g = pending.pop_front();
      if (got.granted !== exp_g.granted) begin
        $error("granted: expected %0d, got %0d", exp_g.granted, got.granted);
        errors++;
      end
      if (got.chosen_block !== exp_g.chosen_block) begin
        $error("chosen_block: expected %0d, got %0d", exp_g.chosen_block, got.chosen_block);
        errors++;
      end
      if (got.space_left !== exp_g.space_left) begin
        $error("space_left: expected %0d, got %0d", exp_g.space_left, got.space_left);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [PdataW-1:0]  pwdata;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  fpba_in_if  in_if ();
  fpba_out_if out_if ();

  alloc_scoreboard sb = new();
  int              src_calm = 0;

  logic [PolicyW-1:0] phase_pol [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1};
  logic [BlocksW-1:0] phase_blk [8] = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd1, 4'd15, 4'd0, 4'd5};

  fit_policy_block_allocator_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(mode_e m, logic [IdxW-1:0] idx, logic [ValW-1:0] sz);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.load_index <= idx;
    in_if.size_value <= sz;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_item(m, idx, sz);
  endtask

  task automatic apb_write(reg_idx_e r, logic [PdataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic set_config(logic [PolicyW-1:0] pol, logic [BlocksW-1:0] blk);
    in_if.valid <= 1'b0;
    drain();
    apb_write(REG_POLICY, PdataW'(pol));
    apb_write(REG_BLOCKS, PdataW'(blk));
  endtask

  task automatic random_item();
    int              r;
    int              k;
    logic [ValW-1:0] sz;
    logic [ValW-1:0] e;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < 35) begin
      if (k < 40) sz = ValW'($urandom_range(0, 16'hffff));
      else if (k < 70) sz = ValW'($urandom_range(0, 255));
      else if (k < 80) sz = 16'hffff;
      else if (k < 90) sz = '0;
      else sz = ValW'($urandom_range(8, 4095));
      push_item(MODE_LOAD, IdxW'($urandom_range(0, 7)), sz);
    end else begin
      if (k < 30) sz = ValW'($urandom_range(0, 127));
      else if (k < 55) begin
        // aim at an entry's current size to hit exact and near fits
        e = sb.free_tbl[$urandom_range(0, Blocks - 1)];
        case ($urandom_range(0, 2))
          0:       sz = e;
          1:       sz = e + 16'd1;
          default: sz = e - 16'd1;
        endcase
      end
      else if (k < 70) sz = ValW'($urandom_range(0, 16'hffff));
      else if (k < 80) sz = '0;
      else if (k < 85) sz = 16'hffff;
      else sz = ValW'($urandom_range(1, 2047));
      push_item(MODE_REQ, IdxW'($urandom_range(0, 7)), sz);
    end
  endtask

  initial begin : result_sink
    int     gap;
    int     calm;
    int     seen;
    grant_t got;
    calm = 0;
    seen = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // one long hold-off so the block fills up and stalls its input
      if (seen == HoldAtCount) gap = HoldCycles;
      else gap = pick_gap(calm);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.granted      = out_if.granted;
      got.chosen_block = out_if.chosen_block;
      got.space_left   = out_if.space_left;
      sb.check_result(got);
      seen++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.mode       <= MODE_LOAD;
    in_if.load_index <= '0;
    in_if.size_value <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset: zero request fits, one unit does not
    push_item(MODE_REQ, 3'd5, 16'd0);
    push_item(MODE_REQ, 3'd2, 16'd1);
    push_item(MODE_LOAD, 3'd0, 16'd100);
    push_item(MODE_LOAD, 3'd1, 16'hffff);
    push_item(MODE_LOAD, 3'd2, 16'd50);
    push_item(MODE_LOAD, 3'd3, 16'd300);
    push_item(MODE_LOAD, 3'd4, 16'd50);
    push_item(MODE_LOAD, 3'd5, 16'd0);
    push_item(MODE_LOAD, 3'd6, 16'd300);
    push_item(MODE_LOAD, 3'd7, 16'd1);
    push_item(MODE_REQ, 3'd7, 16'd50);
    push_item(MODE_REQ, 3'd0, 16'hffff);
    set_config(POL_BEST, 4'd8);
    push_item(MODE_REQ, 3'd0, 16'd40);
    push_item(MODE_REQ, 3'd0, 16'd301);
    set_config(POL_WORST, 4'd8);
    push_item(MODE_REQ, 3'd0, 16'd10);
    push_item(MODE_REQ, 3'd0, 16'd0);
    set_config(2'd3, 4'd8);
    push_item(MODE_REQ, 3'd0, 16'd5);
    set_config(POL_FIRST, 4'd0);
    push_item(MODE_REQ, 3'd0, 16'd0);
    set_config(POL_WORST, 4'd15);
    push_item(MODE_REQ, 3'd0, 16'd1);
    set_config(POL_BEST, 4'd1);
    push_item(MODE_REQ, 3'd0, 16'd6);
    push_item(MODE_LOAD, 3'd7, 16'hffff);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 8) set_config(phase_pol[ph], phase_blk[ph]);
      else set_config(PolicyW'($urandom_range(0, 3)), BlocksW'($urandom_range(0, 15)));
      repeat (168) random_item();
    end

    in_if.valid <= 1'b0;
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected result transactions never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
